// ----- design/cbfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the circular brush falloff stamp.
// Used by the top level and by the divider pipeline.
package cbfs_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int REG_W          = 18;
    localparam int AMT_W          = 17;
    localparam int CFG_IDX_W      = 2;

    localparam logic [AMT_W-1:0] ONE_Q16 = AMT_W'(65536);
    localparam logic [REG_W-1:0] THREE_Q16 = REG_W'(196608);

    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_MODE   = 2'd2;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_FULL = 2'd1,
        SEL_DIV  = 2'd2
    } paint_sel_t;

endpackage

// ----- design/cbfs_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on nothing; a sideband word travels alongside each radicand.
module cbfs_sqrt #(
    parameter int RT_W = 21,
    parameter int SB_W = 17
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RT_W-1:0] in_rad,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [RT_W-1:0]   out_root,
    output logic [SB_W-1:0]   out_sb
);

    localparam int RW = RT_W + 2;

    logic [2*RT_W-1:0] rad_reg  [0:RT_W-1];
    logic [RW-1:0]     rem_reg  [0:RT_W-1];
    logic [RT_W-1:0]   root_reg [0:RT_W-1];
    logic [SB_W-1:0]   sb_reg   [0:RT_W-1];
    logic              vld_reg  [0:RT_W-1];

    genvar k;
    generate
        for (k = 0; k < RT_W; k++) begin : g_stage
            logic [2*RT_W-1:0] rad_in;
            logic [RW-1:0]     rem_in;
            logic [RT_W-1:0]   root_in;
            logic [SB_W-1:0]   sb_in;
            logic              vld_in;
            logic [RW-1:0]     cand;
            logic [RW-1:0]     trial;
            logic              ge;

            if (k == 0) begin : g_first
                assign rad_in  = in_rad;
                assign rem_in  = '0;
                assign root_in = '0;
                assign sb_in   = in_sb;
                assign vld_in  = in_valid;
            end else begin : g_next
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign sb_in   = sb_reg[k-1];
                assign vld_in  = vld_reg[k-1];
            end

            assign cand  = {rem_in[RW-3:0], rad_in[2*RT_W-1 -: 2]};
            assign trial = {root_in, 2'b01};
            assign ge    = cand >= trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= {rad_in[2*RT_W-3:0], 2'b00};
                    rem_reg[k]  <= ge ? cand - trial : cand;
                    root_reg[k] <= {root_in[RT_W-2:0], ge};
                    sb_reg[k]   <= sb_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[RT_W-1];
    assign out_root  = root_reg[RT_W-1];
    assign out_sb    = sb_reg[RT_W-1];

endmodule

// ----- design/cbfs_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider for the falloff ratio a * 2^16 / width, a <= width.
// Depends on cbfs_pkg; one quotient bit per register stage.
module cbfs_div
    import cbfs_pkg::*;
#(
    parameter int SB_W = 19
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [REG_W-1:0] width,
    input  logic             in_valid,
    input  logic [REG_W-1:0] in_num,
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [AMT_W-1:0] out_quot,
    output logic [SB_W-1:0]  out_sb
);

    logic [REG_W-1:0] rem_reg  [0:AMT_W-1];
    logic [AMT_W-1:0] quot_reg [0:AMT_W-1];
    logic [SB_W-1:0]  sb_reg   [0:AMT_W-1];
    logic             vld_reg  [0:AMT_W-1];

    genvar k;
    generate
        for (k = 0; k < AMT_W; k++) begin : g_stage
            logic [REG_W:0]   cand;
            logic [AMT_W-1:0] quot_in;
            logic [SB_W-1:0]  sb_in;
            logic             vld_in;
            logic             ge;
            logic [REG_W:0]   diff;

            if (k == 0) begin : g_first
                assign cand    = {1'b0, in_num};
                assign quot_in = '0;
                assign sb_in   = in_sb;
                assign vld_in  = in_valid;
            end else begin : g_next
                assign cand    = {rem_reg[k-1], 1'b0};
                assign quot_in = quot_reg[k-1];
                assign sb_in   = sb_reg[k-1];
                assign vld_in  = vld_reg[k-1];
            end

            assign ge   = cand >= {1'b0, width};
            assign diff = cand - {1'b0, width};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= ge ? diff[REG_W-1:0] : cand[REG_W-1:0];
                    quot_reg[k] <= {quot_in[AMT_W-2:0], ge};
                    sb_reg[k]   <= sb_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[AMT_W-1];
    assign out_quot  = quot_reg[AMT_W-1];
    assign out_sb    = sb_reg[AMT_W-1];

endmodule

// ----- design/circular_brush_falloff_stamp.sv -----
`timescale 1ns / 1ps
// Circular brush stamp: one pixel word in, one amount word out, one word per cycle unless
// the output word is held. Stages: three delta, square and sum stages, one stage per root
// bit (COORD_BITS+FRAC_BITS+1), one classify stage, seventeen divider stages and three
// smoothstep and output stages. A held output word freezes the whole pipeline. Depends on
// cbfs_pkg, cbfs_sqrt and cbfs_div; write registers only while idle.
module circular_brush_falloff_stamp
    import cbfs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int D_W  = COORD_BITS + FRAC_BITS,
    localparam int IN_W = ((2 * COORD_BITS + 2 * D_W + AMT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pixel_x, pixel_y, center_x, center_y, prev_amount, from bit 0 up
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // new_amount
    output logic [23:0]          m_tdata,
    // written
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    localparam int SUM_W = 2 * D_W + 1;
    localparam int RT_W  = D_W + 1;
    localparam int CW    = (RT_W > REG_W) ? RT_W : REG_W;
    localparam int SB2_W = AMT_W + 2;

    logic [REG_W-1:0] inner_reg, falloff_reg;
    logic             smooth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_reg   <= '0;
            falloff_reg <= '0;
            smooth_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_INNER_RADIUS:  inner_reg   <= cfg_data;
                CFG_FALLOFF_WIDTH: falloff_reg <= cfg_data;
                CFG_SMOOTH_MODE:   smooth_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    logic [COORD_BITS-1:0] pix_x, pix_y;
    logic [D_W-1:0]        cen_x, cen_y, px, py;
    logic [AMT_W-1:0]      prev_in;

    assign pix_x   = s_tdata[COORD_BITS-1:0];
    assign pix_y   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign cen_x   = s_tdata[2*COORD_BITS+D_W-1:2*COORD_BITS];
    assign cen_y   = s_tdata[2*COORD_BITS+2*D_W-1:2*COORD_BITS+D_W];
    assign prev_in = s_tdata[2*COORD_BITS+2*D_W+AMT_W-1:2*COORD_BITS+2*D_W];
    assign px      = {pix_x, {FRAC_BITS{1'b0}}};
    assign py      = {pix_y, {FRAC_BITS{1'b0}}};

    // Stage 1: absolute axis deltas.
    logic [D_W-1:0]   dx_reg, dy_reg;
    logic [AMT_W-1:0] prev1_reg;
    logic             v1_reg;
    // Stage 2: squares.
    logic [2*D_W-1:0] sqx_reg, sqy_reg;
    logic [AMT_W-1:0] prev2_reg;
    logic             v2_reg;
    // Stage 3: sum of squares.
    logic [SUM_W-1:0] sum_reg;
    logic [AMT_W-1:0] prev3_reg;
    logic             v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= (px >= cen_x) ? px - cen_x : cen_x - px;
            dy_reg    <= (py >= cen_y) ? py - cen_y : cen_y - py;
            prev1_reg <= prev_in;
            sqx_reg   <= dx_reg * dx_reg;
            sqy_reg   <= dy_reg * dy_reg;
            prev2_reg <= prev1_reg;
            sum_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            prev3_reg <= prev2_reg;
        end
    end

    logic             v4;
    logic [RT_W-1:0]  dist_root;
    logic [AMT_W-1:0] prev4;

    cbfs_sqrt #(
        .RT_W (RT_W),
        .SB_W (AMT_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    ({1'b0, sum_reg}),
        .in_sb     (prev3_reg),
        .out_valid (v4),
        .out_root  (dist_root),
        .out_sb    (prev4)
    );

    // Stage 5: classify distance against the ring.
    logic [CW-1:0]    dist_w, inner_w, falloff_w, t_w;
    logic [REG_W-1:0] a_reg;
    paint_sel_t       sel_next, sel_reg;
    logic [AMT_W-1:0] prev5_reg;
    logic             v5_reg;

    assign dist_w    = CW'(dist_root);
    assign inner_w   = CW'(inner_reg);
    assign falloff_w = CW'(falloff_reg);
    assign t_w       = dist_w - inner_w;

    always_comb begin
        if (dist_w < inner_w) begin
            sel_next = SEL_FULL;
        end else if (falloff_reg != '0 && t_w < falloff_w) begin
            sel_next = SEL_DIV;
        end else begin
            sel_next = SEL_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= falloff_reg - t_w[REG_W-1:0];
            sel_reg   <= sel_next;
            prev5_reg <= prev4;
        end
    end

    logic             v6;
    logic [AMT_W-1:0] quot;
    logic [SB2_W-1:0] sb6;
    paint_sel_t       sel6;
    logic [AMT_W-1:0] prev6;

    cbfs_div #(
        .SB_W (SB2_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .width     (falloff_reg),
        .in_valid  (v5_reg),
        .in_num    (a_reg),
        .in_sb     ({sel_reg, prev5_reg}),
        .out_valid (v6),
        .out_quot  (quot),
        .out_sb    (sb6)
    );

    assign sel6  = paint_sel_t'(sb6[SB2_W-1:AMT_W]);
    assign prev6 = sb6[AMT_W-1:0];

    // Stage 7: linear value, its square and the smoothstep factor.
    logic [AMT_W-1:0]   y_lin;
    logic [AMT_W-1:0]   y7_reg;
    logic [2*AMT_W-1:0] ysq_reg;
    logic [REG_W-1:0]   k_reg;
    logic [AMT_W-1:0]   prev7_reg;
    logic               v7_reg;

    always_comb begin
        case (sel6)
            SEL_FULL: y_lin = ONE_Q16;
            SEL_DIV:  y_lin = quot;
            default:  y_lin = '0;
        endcase
    end

    // Stage 8: smoothstep product, or the linear value when smoothing is off.
    logic [2*AMT_W+REG_W-1:0] prod;
    logic [AMT_W-1:0]         paint_reg;
    logic [AMT_W-1:0]         prev8_reg;
    logic                     v8_reg;

    assign prod = ysq_reg * k_reg;

    // Stage 9: output word.
    logic             wr;
    logic [AMT_W-1:0] new_amount_reg;
    logic             written_reg;

    assign wr = (paint_reg != '0) && (paint_reg > prev8_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v7_reg        <= v6;
            v8_reg        <= v7_reg;
            out_valid_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y7_reg         <= y_lin;
            ysq_reg        <= y_lin * y_lin;
            k_reg          <= THREE_Q16 - {y_lin, 1'b0};
            prev7_reg      <= prev6;
            paint_reg      <= smooth_reg ? prod[32+AMT_W-1:32] : y7_reg;
            prev8_reg      <= prev7_reg;
            new_amount_reg <= wr ? paint_reg : prev8_reg;
            written_reg    <= wr;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - AMT_W){1'b0}}, new_amount_reg};
    assign m_tuser  = written_reg;

endmodule
